### src/tllpc_pkg.sv
package tllpc_pkg;

   localparam int ENTRIES    = 512;
   localparam int PAGE_BYTES = 4096;
   localparam int WORD_BITS  = 64;

   localparam int SLOT_W   = $clog2(ENTRIES);
   localparam int SIZE_W   = $clog2(ENTRIES + 1);
   localparam int WORDS    = (PAGE_BYTES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W   = $clog2(WORDS);
   localparam int BIT_W    = $clog2(WORD_BITS);
   localparam int TM_DEPTH = ENTRIES * WORDS;
   localparam int BYTE_W   = $clog2(PAGE_BYTES + 1);

   // fixed field widths
   localparam int TAG_W  = 52;
   localparam int OFF_W  = 12;
   localparam int CNT_W  = 13;
   localparam int EVB_W  = 13;
   localparam int MAXP_W = 9;
   localparam int FLAG_W = 3;
   localparam int KIND_W = 2;
   localparam int OP_W   = 5;

   localparam logic [FLAG_W-1:0] F_VALID  = 3'b001;
   localparam logic [FLAG_W-1:0] F_ACTIVE = 3'b010;
   localparam logic [FLAG_W-1:0] F_DIRTY  = 3'b100;

   localparam logic [KIND_W-1:0] KIND_MISS     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INACTIVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACTIVE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DRAIN    = 2'd3;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
   localparam logic [OP_W-1:0] OP_CLEAR       = 5'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT      = 5'd2;
   localparam logic [OP_W-1:0] OP_SCAN        = 5'd3;
   localparam logic [OP_W-1:0] OP_SWEEP_START = 5'd4;
   localparam logic [OP_W-1:0] OP_MARK        = 5'd5;
   localparam logic [OP_W-1:0] OP_COUNT       = 5'd6;
   localparam logic [OP_W-1:0] OP_FILL        = 5'd7;
   localparam logic [OP_W-1:0] OP_HIT_FLAG    = 5'd8;
   localparam logic [OP_W-1:0] OP_READ        = 5'd9;
   localparam logic [OP_W-1:0] OP_POP         = 5'd10;
   localparam logic [OP_W-1:0] OP_UNLINK      = 5'd11;
   localparam logic [OP_W-1:0] OP_PUSH        = 5'd12;
   localparam logic [OP_W-1:0] OP_DEMOTE_FLAG = 5'd13;
   localparam logic [OP_W-1:0] OP_EVICT       = 5'd14;
   localparam logic [OP_W-1:0] OP_ALLOC_RD    = 5'd15;
   localparam logic [OP_W-1:0] OP_ALLOC       = 5'd16;
   localparam logic [OP_W-1:0] OP_RESULT      = 5'd17;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              lst;
      logic              use_aux;
      logic [KIND_W-1:0] kind;
      logic              empty;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic match;
      logic scan_last;
      logic sweep_done;
      logic fill_last;
      logic size0_zero;
      logic size1_zero;
      logic total_zero;
      logic need_evict;
      logic demote;
      logic hit_active;
      logic fc_zero;
      logic out_free;
      logic drain;
   } status_type;

endpackage

### src/tllpc_ram.sv
module tllpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tllpc_dp.sv
module tllpc_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  tllpc_pkg::cmd_type           cmd,
   output tllpc_pkg::status_type        status,
   input  logic                         csr_wr_en,
   input  logic [tllpc_pkg::MAXP_W-1:0] csr_wr_data,
   input  logic                         req_type,
   input  logic [tllpc_pkg::TAG_W-1:0]  req_page_number,
   input  logic [tllpc_pkg::OFF_W-1:0]  req_byte_offset,
   input  logic [tllpc_pkg::CNT_W-1:0]  req_byte_count,
   input  logic                         req_is_write,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tllpc_pkg::KIND_W-1:0] rsp_hit_kind,
   output logic                         rsp_evict_valid,
   output logic [tllpc_pkg::TAG_W-1:0]  rsp_evicted_page,
   output logic [tllpc_pkg::EVB_W-1:0]  rsp_evicted_bytes,
   output logic                         rsp_evicted_dirty,
   output logic                         rsp_cache_empty
);
   import tllpc_pkg::*;

   localparam int TM_AW = SLOT_W + WORD_W;
   localparam logic [BYTE_W-1:0] BYTES_SAT = BYTE_W'((1 << EVB_W) - 1);

   function automatic logic [WORD_BITS-1:0] word_mask(input logic [WORD_W-1:0] w,
                                                      input logic [OFF_W-1:0]  lo_in,
                                                      input logic [BYTE_W-1:0] hi_in);
      logic [BYTE_W:0]    base;
      logic [BYTE_W:0]    lo_b;
      logic [BYTE_W:0]    hi_b;
      logic [BYTE_W:0]    lo;
      logic [BYTE_W:0]    hi;
      logic [WORD_BITS:0] ml;
      logic [WORD_BITS:0] mh;
      base = (BYTE_W + 1)'(w) << BIT_W;
      lo_b = (BYTE_W + 1)'(lo_in);
      hi_b = (BYTE_W + 1)'(hi_in);
      lo   = (lo_b > base) ? lo_b - base : '0;
      hi   = (hi_b > base) ? hi_b - base : '0;
      if (lo > (BYTE_W + 1)'(WORD_BITS)) lo = (BYTE_W + 1)'(WORD_BITS);
      if (hi > (BYTE_W + 1)'(WORD_BITS)) hi = (BYTE_W + 1)'(WORD_BITS);
      mh = ((WORD_BITS + 1)'(1) << hi) - (WORD_BITS + 1)'(1);
      ml = ((WORD_BITS + 1)'(1) << lo) - (WORD_BITS + 1)'(1);
      return mh[WORD_BITS-1:0] & ~ml[WORD_BITS-1:0];
   endfunction

   function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         n = n + (BIT_W + 1)'(v[i]);
      end
      return n;
   endfunction

   // control registers
   logic [MAXP_W-1:0] max_pages_ff, max_pages_in;
   logic [SLOT_W-1:0] head_ff [2], head_in [2];
   logic [SLOT_W-1:0] tail_ff [2], tail_in [2];
   logic [SIZE_W-1:0] size_ff [2], size_in [2];
   logic [SIZE_W-1:0] fc_ff, fc_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              pv_ff, pv_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic              drain_ff, drain_in;
   logic [TAG_W-1:0]  page_ff, page_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [BYTE_W-1:0] end_ff, end_in;
   logic              wr_ff, wr_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] cmp_ff, cmp_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] aux_ff, aux_in;
   logic [FLAG_W-1:0] hitflag_ff, hitflag_in;
   logic [TAG_W-1:0]  x_tag_ff, x_tag_in;
   logic [FLAG_W-1:0] x_flags_ff, x_flags_in;
   logic [WORD_W:0]   w_ff, w_in;
   logic [WORD_W-1:0] wp_ff, wp_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic              st_valid_ff, st_valid_in;
   logic [TAG_W-1:0]  st_page_ff, st_page_in;
   logic [BYTE_W-1:0] st_bytes_ff, st_bytes_in;
   logic              st_dirty_ff, st_dirty_in;
   logic [KIND_W-1:0] o_kind_ff, o_kind_in;
   logic              o_ev_ff, o_ev_in;
   logic [TAG_W-1:0]  o_page_ff, o_page_in;
   logic [EVB_W-1:0]  o_bytes_ff, o_bytes_in;
   logic              o_dirty_ff, o_dirty_in;
   logic              o_empty_ff, o_empty_in;

   // memory ports
   logic              tag_we;
   logic [SLOT_W-1:0] tag_wa;
   logic [SLOT_W-1:0] tag_ra;
   logic [TAG_W-1:0]  tag_rd;
   logic              flags_we;
   logic [SLOT_W-1:0] flags_wa;
   logic [FLAG_W-1:0] flags_wd;
   logic [FLAG_W-1:0] flags_rd;
   logic [SLOT_W-1:0] link_ra;
   logic              next_we;
   logic [SLOT_W-1:0] next_wa;
   logic [SLOT_W-1:0] next_wd;
   logic [SLOT_W-1:0] next_rd;
   logic              prev_we;
   logic [SLOT_W-1:0] prev_wa;
   logic [SLOT_W-1:0] prev_wd;
   logic [SLOT_W-1:0] prev_rd;
   logic              free_we;
   logic [SLOT_W-1:0] free_wa;
   logic [SLOT_W-1:0] free_wd;
   logic [SLOT_W-1:0] free_ra;
   logic [SLOT_W-1:0] free_rd;
   logic              tm_we;
   logic [TM_AW-1:0]  tm_wa;
   logic [WORD_BITS-1:0] tm_wd;
   logic [TM_AW-1:0]  tm_ra;
   logic [WORD_BITS-1:0] tm_rd;

   logic [SLOT_W-1:0] x;
   logic [SLOT_W-1:0] hd;
   logic [SLOT_W-1:0] tl;
   logic [SIZE_W-1:0] sz;
   logic [CNT_W:0]    byte_sum;
   logic [SIZE_W:0]   total;

   tllpc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tags (
      .clock, .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(page_ff),
      .rd_addr(tag_ra), .rd_data(tag_rd));

   tllpc_ram #(.WIDTH(FLAG_W), .DEPTH(ENTRIES)) u_flags (
      .clock, .wr_en(flags_we), .wr_addr(flags_wa), .wr_data(flags_wd),
      .rd_addr(tag_ra), .rd_data(flags_rd));

   tllpc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_next (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(link_ra), .rd_data(next_rd));

   tllpc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_prev (
      .clock, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(link_ra), .rd_data(prev_rd));

   tllpc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_free (
      .clock, .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd));

   tllpc_ram #(.WIDTH(WORD_BITS), .DEPTH(TM_DEPTH)) u_touched (
      .clock, .wr_en(tm_we), .wr_addr(tm_wa), .wr_data(tm_wd),
      .rd_addr(tm_ra), .rd_data(tm_rd));

   assign x        = cmd.use_aux ? aux_ff : slot_ff;
   assign hd       = cmd.lst ? head_ff[1] : head_ff[0];
   assign tl       = cmd.lst ? tail_ff[1] : tail_ff[0];
   assign sz       = cmd.lst ? size_ff[1] : size_ff[0];
   assign byte_sum = (CNT_W + 1)'(req_byte_offset) + (CNT_W + 1)'(req_byte_count);
   assign total    = (SIZE_W + 1)'(size_ff[0]) + (SIZE_W + 1)'(size_ff[1]);

   always_comb begin
      max_pages_in = max_pages_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      size_in      = size_ff;
      fc_in        = fc_ff;
      clr_in       = clr_ff;
      cmp_vld_in   = cmp_vld_ff;
      pv_in        = pv_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      drain_in     = drain_ff;
      page_in      = page_ff;
      off_in       = off_ff;
      end_in       = end_ff;
      wr_in        = wr_ff;
      scan_in      = scan_ff;
      cmp_in       = cmp_ff;
      slot_in      = slot_ff;
      aux_in       = aux_ff;
      hitflag_in   = hitflag_ff;
      x_tag_in     = x_tag_ff;
      x_flags_in   = x_flags_ff;
      w_in         = w_ff;
      wp_in        = wp_ff;
      acc_in       = acc_ff;
      st_valid_in  = st_valid_ff;
      st_page_in   = st_page_ff;
      st_bytes_in  = st_bytes_ff;
      st_dirty_in  = st_dirty_ff;
      o_kind_in    = o_kind_ff;
      o_ev_in      = o_ev_ff;
      o_page_in    = o_page_ff;
      o_bytes_in   = o_bytes_ff;
      o_dirty_in   = o_dirty_ff;
      o_empty_in   = o_empty_ff;

      tag_we   = 1'b0;
      tag_wa   = slot_ff;
      tag_ra   = scan_ff;
      flags_we = 1'b0;
      flags_wa = slot_ff;
      flags_wd = '0;
      link_ra  = slot_ff;
      next_we  = 1'b0;
      next_wa  = x;
      next_wd  = hd;
      prev_we  = 1'b0;
      prev_wa  = hd;
      prev_wd  = x;
      free_we  = 1'b0;
      free_wa  = fc_ff[SLOT_W-1:0];
      free_wd  = aux_ff;
      free_ra  = SLOT_W'(fc_ff - SIZE_W'(1));
      tm_we    = 1'b0;
      tm_wa    = {slot_ff, wp_ff};
      tm_wd    = '0;
      tm_ra    = {slot_ff, w_ff[WORD_W-1:0]};

      if (csr_wr_en) begin
         max_pages_in = csr_wr_data;
      end

      unique case (cmd.op)
         OP_CLEAR: begin
            flags_we = 1'b1;
            flags_wa = clr_ff;
            flags_wd = '0;
            free_we  = 1'b1;
            free_wa  = clr_ff;
            free_wd  = SLOT_W'(ENTRIES - 1) - clr_ff;
            clr_in   = clr_ff + SLOT_W'(1);
         end
         OP_ACCEPT: begin
            drain_in    = req_type;
            page_in     = req_page_number;
            off_in      = req_byte_offset;
            end_in      = (byte_sum > (CNT_W + 1)'(PAGE_BYTES)) ? BYTE_W'(PAGE_BYTES)
                                                                : BYTE_W'(byte_sum);
            wr_in       = req_is_write;
            scan_in     = '0;
            cmp_vld_in  = 1'b0;
            st_valid_in = 1'b0;
            st_page_in  = '0;
            st_bytes_in = '0;
            st_dirty_in = 1'b0;
         end
         OP_SCAN: begin
            tag_ra     = scan_ff;
            scan_in    = scan_ff + SLOT_W'(1);
            cmp_in     = scan_ff;
            cmp_vld_in = 1'b1;
            if (status.match) begin
               slot_in    = cmp_ff;
               hitflag_in = flags_rd;
            end
         end
         OP_SWEEP_START: begin
            w_in   = '0;
            pv_in  = 1'b0;
            acc_in = '0;
         end
         OP_MARK: begin
            // read one word ahead, write back the word read last cycle
            tm_ra = {slot_ff, w_ff[WORD_W-1:0]};
            if (!w_ff[WORD_W]) w_in = w_ff + (WORD_W + 1)'(1);
            pv_in = !w_ff[WORD_W];
            wp_in = w_ff[WORD_W-1:0];
            if (pv_ff) begin
               tm_we = 1'b1;
               tm_wa = {slot_ff, wp_ff};
               tm_wd = tm_rd | word_mask(wp_ff, off_ff, end_ff);
            end
         end
         OP_COUNT: begin
            tm_ra = {aux_ff, w_ff[WORD_W-1:0]};
            if (!w_ff[WORD_W]) w_in = w_ff + (WORD_W + 1)'(1);
            pv_in = !w_ff[WORD_W];
            wp_in = w_ff[WORD_W-1:0];
            if (pv_ff) acc_in = acc_ff + BYTE_W'(popcount(tm_rd));
         end
         OP_FILL: begin
            tm_we = 1'b1;
            tm_wa = {slot_ff, w_ff[WORD_W-1:0]};
            tm_wd = word_mask(w_ff[WORD_W-1:0], off_ff, end_ff);
            w_in  = w_ff + (WORD_W + 1)'(1);
         end
         OP_HIT_FLAG: begin
            flags_we = 1'b1;
            flags_wa = slot_ff;
            flags_wd = hitflag_ff | F_ACTIVE | (wr_ff ? F_DIRTY : '0);
         end
         OP_READ: begin
            link_ra = slot_ff;
            tag_ra  = slot_ff;
         end
         OP_POP: begin
            aux_in  = tl;
            link_ra = tl;
            tag_ra  = tl;
         end
         OP_UNLINK: begin
            x_tag_in   = tag_rd;
            x_flags_in = flags_rd;
            if (sz != '0) begin
               if (sz > SIZE_W'(1)) begin
                  if (x == hd) begin
                     head_in[cmd.lst] = next_rd;
                  end else if (x == tl) begin
                     tail_in[cmd.lst] = prev_rd;
                  end else begin
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = next_rd;
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = prev_rd;
                  end
               end
               size_in[cmd.lst] = sz - SIZE_W'(1);
            end
         end
         OP_PUSH: begin
            if (sz == '0) begin
               head_in[cmd.lst] = x;
               tail_in[cmd.lst] = x;
            end else begin
               next_we = 1'b1;
               next_wa = x;
               next_wd = hd;
               prev_we = 1'b1;
               prev_wa = hd;
               prev_wd = x;
               head_in[cmd.lst] = x;
            end
            size_in[cmd.lst] = sz + SIZE_W'(1);
         end
         OP_DEMOTE_FLAG: begin
            flags_we = 1'b1;
            flags_wa = aux_ff;
            flags_wd = x_flags_ff & ~F_ACTIVE;
         end
         OP_EVICT: begin
            flags_we = 1'b1;
            flags_wa = aux_ff;
            flags_wd = '0;
            if (fc_ff < SIZE_W'(ENTRIES)) begin
               free_we = 1'b1;
               free_wa = fc_ff[SLOT_W-1:0];
               free_wd = aux_ff;
               fc_in   = fc_ff + SIZE_W'(1);
            end
            st_valid_in = 1'b1;
            st_page_in  = x_tag_ff;
            st_bytes_in = acc_ff;
            st_dirty_in = (x_flags_ff & F_DIRTY) != '0;
         end
         OP_ALLOC_RD: begin
            fc_in = fc_ff - SIZE_W'(1);
         end
         OP_ALLOC: begin
            slot_in  = free_rd;
            tag_we   = 1'b1;
            tag_wa   = free_rd;
            flags_we = 1'b1;
            flags_wa = free_rd;
            flags_wd = F_VALID | (wr_ff ? F_DIRTY : '0);
         end
         OP_RESULT: begin
            rsp_valid_in = 1'b1;
            o_kind_in    = cmd.kind;
            o_empty_in   = cmd.empty;
            o_ev_in      = st_valid_ff;
            o_page_in    = st_page_ff;
            o_bytes_in   = (st_bytes_ff > BYTES_SAT) ? EVB_W'(BYTES_SAT)
                                                     : EVB_W'(st_bytes_ff);
            o_dirty_in   = st_dirty_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pages_ff <= MAXP_W'(389);
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         size_ff      <= '{default: '0};
         fc_ff        <= SIZE_W'(ENTRIES);
         clr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_pages_ff <= max_pages_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         size_ff      <= size_in;
         fc_ff        <= fc_in;
         clr_ff       <= clr_in;
         cmp_vld_ff   <= cmp_vld_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drain_ff    <= drain_in;
      page_ff     <= page_in;
      off_ff      <= off_in;
      end_ff      <= end_in;
      wr_ff       <= wr_in;
      scan_ff     <= scan_in;
      cmp_ff      <= cmp_in;
      slot_ff     <= slot_in;
      aux_ff      <= aux_in;
      hitflag_ff  <= hitflag_in;
      x_tag_ff    <= x_tag_in;
      x_flags_ff  <= x_flags_in;
      w_ff        <= w_in;
      wp_ff       <= wp_in;
      acc_ff      <= acc_in;
      st_valid_ff <= st_valid_in;
      st_page_ff  <= st_page_in;
      st_bytes_ff <= st_bytes_in;
      st_dirty_ff <= st_dirty_in;
      o_kind_ff   <= o_kind_in;
      o_ev_ff     <= o_ev_in;
      o_page_ff   <= o_page_in;
      o_bytes_ff  <= o_bytes_in;
      o_dirty_ff  <= o_dirty_in;
      o_empty_ff  <= o_empty_in;
   end

   always_comb begin
      status.clear_last = clr_ff == SLOT_W'(ENTRIES - 1);
      status.match      = cmp_vld_ff && ((flags_rd & F_VALID) != '0) && (tag_rd == page_ff);
      status.scan_last  = cmp_vld_ff && (cmp_ff == SLOT_W'(ENTRIES - 1));
      status.sweep_done = pv_ff && (wp_ff == WORD_W'(WORDS - 1));
      status.fill_last  = w_ff == (WORD_W + 1)'(WORDS - 1);
      status.size0_zero = size_ff[0] == '0;
      status.size1_zero = size_ff[1] == '0;
      status.total_zero = total == '0;
      status.need_evict = (total > (SIZE_W + 1)'(max_pages_ff)) || (fc_ff == '0);
      status.demote     = size_ff[1] > size_ff[0];
      status.hit_active = (hitflag_ff & F_ACTIVE) != '0;
      status.fc_zero    = fc_ff == '0;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
      status.drain      = drain_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit_kind      = o_kind_ff;
   assign rsp_evict_valid   = o_ev_ff;
   assign rsp_evicted_page  = o_page_ff;
   assign rsp_evicted_bytes = o_bytes_ff;
   assign rsp_evicted_dirty = o_dirty_ff;
   assign rsp_cache_empty   = o_empty_ff;

endmodule

### src/tllpc_ctrl.sv
module tllpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  idle,
   input  tllpc_pkg::status_type status,
   output tllpc_pkg::cmd_type    cmd
);
   import tllpc_pkg::*;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_CLEAR     = 5'd0;
   localparam logic [ST_W-1:0] S_IDLE      = 5'd1;
   localparam logic [ST_W-1:0] S_DISPATCH  = 5'd2;
   localparam logic [ST_W-1:0] S_SCAN      = 5'd3;
   localparam logic [ST_W-1:0] S_H_WSTART  = 5'd4;
   localparam logic [ST_W-1:0] S_H_MARK    = 5'd5;
   localparam logic [ST_W-1:0] S_H_FLAG    = 5'd6;
   localparam logic [ST_W-1:0] S_H_READ    = 5'd7;
   localparam logic [ST_W-1:0] S_H_UNLINK  = 5'd8;
   localparam logic [ST_W-1:0] S_H_CHK     = 5'd9;
   localparam logic [ST_W-1:0] S_D_POP     = 5'd10;
   localparam logic [ST_W-1:0] S_D_UNLINK  = 5'd11;
   localparam logic [ST_W-1:0] S_D_FLAG    = 5'd12;
   localparam logic [ST_W-1:0] S_D_PUSH    = 5'd13;
   localparam logic [ST_W-1:0] S_H_PUSH    = 5'd14;
   localparam logic [ST_W-1:0] S_M_CHK     = 5'd15;
   localparam logic [ST_W-1:0] S_E_POP     = 5'd16;
   localparam logic [ST_W-1:0] S_E_UNLINK  = 5'd17;
   localparam logic [ST_W-1:0] S_E_WSTART  = 5'd18;
   localparam logic [ST_W-1:0] S_E_COUNT   = 5'd19;
   localparam logic [ST_W-1:0] S_E_EVICT   = 5'd20;
   localparam logic [ST_W-1:0] S_M_FREE    = 5'd21;
   localparam logic [ST_W-1:0] S_A_RD      = 5'd22;
   localparam logic [ST_W-1:0] S_A_WR      = 5'd23;
   localparam logic [ST_W-1:0] S_F_WSTART  = 5'd24;
   localparam logic [ST_W-1:0] S_F_FILL    = 5'd25;
   localparam logic [ST_W-1:0] S_M_PUSH    = 5'd26;
   localparam logic [ST_W-1:0] S_RESULT    = 5'd27;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic              lst_ff, lst_in;
   logic              empty_ff, empty_in;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      lst_in      = lst_ff;
      empty_in    = empty_ff;
      cmd.op      = OP_NONE;
      cmd.lst     = lst_ff;
      cmd.use_aux = 1'b0;
      cmd.kind    = kind_ff;
      cmd.empty   = empty_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               empty_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.drain) begin
               kind_in = KIND_DRAIN;
               if (!status.size0_zero) begin
                  lst_in   = 1'b0;
                  state_in = S_E_POP;
               end else if (!status.size1_zero) begin
                  lst_in   = 1'b1;
                  state_in = S_E_POP;
               end else begin
                  empty_in = 1'b1;
                  state_in = S_RESULT;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.match) state_in = S_H_WSTART;
            else if (status.scan_last) state_in = S_M_CHK;
         end
         S_H_WSTART: begin
            cmd.op   = OP_SWEEP_START;
            state_in = S_H_MARK;
         end
         S_H_MARK: begin
            cmd.op = OP_MARK;
            if (status.sweep_done) state_in = S_H_FLAG;
         end
         S_H_FLAG: begin
            cmd.op   = OP_HIT_FLAG;
            state_in = S_H_READ;
         end
         S_H_READ: begin
            cmd.op   = OP_READ;
            state_in = S_H_UNLINK;
         end
         S_H_UNLINK: begin
            cmd.op  = OP_UNLINK;
            cmd.lst = status.hit_active;
            if (status.hit_active) begin
               kind_in  = KIND_ACTIVE;
               state_in = S_H_PUSH;
            end else begin
               kind_in  = KIND_INACTIVE;
               state_in = S_H_CHK;
            end
         end
         S_H_CHK: begin
            state_in = status.demote ? S_D_POP : S_H_PUSH;
         end
         S_D_POP: begin
            cmd.op   = OP_POP;
            cmd.lst  = 1'b1;
            state_in = S_D_UNLINK;
         end
         S_D_UNLINK: begin
            cmd.op      = OP_UNLINK;
            cmd.lst     = 1'b1;
            cmd.use_aux = 1'b1;
            state_in    = S_D_FLAG;
         end
         S_D_FLAG: begin
            cmd.op   = OP_DEMOTE_FLAG;
            state_in = S_D_PUSH;
         end
         S_D_PUSH: begin
            cmd.op      = OP_PUSH;
            cmd.lst     = 1'b0;
            cmd.use_aux = 1'b1;
            state_in    = S_H_PUSH;
         end
         S_H_PUSH: begin
            cmd.op   = OP_PUSH;
            cmd.lst  = 1'b1;
            state_in = S_RESULT;
         end
         S_M_CHK: begin
            kind_in = KIND_MISS;
            if (!status.total_zero && status.need_evict) begin
               lst_in   = status.size0_zero;
               state_in = S_E_POP;
            end else begin
               state_in = S_M_FREE;
            end
         end
         S_E_POP: begin
            cmd.op   = OP_POP;
            state_in = S_E_UNLINK;
         end
         S_E_UNLINK: begin
            cmd.op      = OP_UNLINK;
            cmd.use_aux = 1'b1;
            state_in    = S_E_WSTART;
         end
         S_E_WSTART: begin
            cmd.op   = OP_SWEEP_START;
            state_in = S_E_COUNT;
         end
         S_E_COUNT: begin
            cmd.op = OP_COUNT;
            if (status.sweep_done) state_in = S_E_EVICT;
         end
         S_E_EVICT: begin
            cmd.op   = OP_EVICT;
            state_in = status.drain ? S_RESULT : S_M_FREE;
         end
         S_M_FREE: begin
            state_in = status.fc_zero ? S_RESULT : S_A_RD;
         end
         S_A_RD: begin
            cmd.op   = OP_ALLOC_RD;
            state_in = S_A_WR;
         end
         S_A_WR: begin
            cmd.op   = OP_ALLOC;
            state_in = S_F_WSTART;
         end
         S_F_WSTART: begin
            cmd.op   = OP_SWEEP_START;
            state_in = S_F_FILL;
         end
         S_F_FILL: begin
            cmd.op = OP_FILL;
            if (status.fill_last) state_in = S_M_PUSH;
         end
         S_M_PUSH: begin
            cmd.op   = OP_PUSH;
            cmd.lst  = 1'b0;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (status.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         kind_ff  <= KIND_MISS;
         lst_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         lst_ff   <= lst_in;
         empty_ff <= empty_in;
      end
   end

   assign idle = state_ff == S_IDLE;

endmodule

### src/two_list_lru_page_cache_core.sv
// Two-list (inactive/active) LRU page cache with per-byte touch tracking. One
// transaction on req_ names a page access or, with req_type high, a drain of one
// resident page; each yields exactly one rsp_ transaction. After reset the block
// sweeps its slot flags and free-slot stack with req_stall high; csr_ writes are
// taken as ever. Items are handled one at a time. An access scans the 512 tag
// slots at one slot a cycle until a match or the last slot, then a hit makes a
// read-modify-write pass over the page's 64 touched-map words plus list work.
// A miss adds, when it must evict, a touched-byte count of the victim, then a
// fill of the new page's map. The tag scan and the touched-map sweeps take most
// of the time.
module two_list_lru_page_cache_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [tllpc_pkg::TAG_W-1:0]  req_page_number,
   input  logic [tllpc_pkg::OFF_W-1:0]  req_byte_offset,
   input  logic [tllpc_pkg::CNT_W-1:0]  req_byte_count,
   input  logic                         req_is_write,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tllpc_pkg::KIND_W-1:0] rsp_hit_kind,
   output logic                         rsp_evict_valid,
   output logic [tllpc_pkg::TAG_W-1:0]  rsp_evicted_page,
   output logic [tllpc_pkg::EVB_W-1:0]  rsp_evicted_bytes,
   output logic                         rsp_evicted_dirty,
   output logic                         rsp_cache_empty,
   input  logic                         csr_wr_en,
   input  logic [tllpc_pkg::MAXP_W-1:0] csr_wr_data
);
   import tllpc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       idle;

   // sequence each transaction; accept only from idle
   tllpc_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid,
      .idle,
      .status,
      .cmd
   );

   // lists, tag/link/flag stores, touched map and the output register
   tllpc_dp u_dp (
      .clock,
      .reset,
      .cmd,
      .status,
      .csr_wr_en,
      .csr_wr_data,
      .req_type,
      .req_page_number,
      .req_byte_offset,
      .req_byte_count,
      .req_is_write,
      .rsp_valid,
      .rsp_stall,
      .rsp_hit_kind,
      .rsp_evict_valid,
      .rsp_evicted_page,
      .rsp_evicted_bytes,
      .rsp_evicted_dirty,
      .rsp_cache_empty
   );

   // hold the request side while clearing or working on a transaction
   assign req_stall = !idle;

endmodule
